// ===== design/scba_pkg.sv =====
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants of the size-class block allocator: request and
// response item layouts, operation and status codes, fixed allocator geometry and pool parameter defaults.
// ----------------------------------------------------------------------------
package scba_pkg;

    // Fixed geometry of the allocator
    localparam int unsigned NUM_CLASSES     = 8;
    localparam int unsigned CLASS_W         = 3;
    localparam int unsigned CLASS_CNT_W     = 4;
    localparam int unsigned CLASS_MIN_BYTES = 8;
    localparam int unsigned CLASS_MIN_SHIFT = 3;
    localparam int unsigned ADDR_W          = 16;
    localparam int unsigned ADDR_SPACE      = 65536;
    localparam int unsigned SIZE_W          = 16;
    localparam int unsigned LINK_DEPTH      = 8192;
    localparam int unsigned LINK_IDX_W      = 13;

    // Parameter defaults for the top level
    localparam int unsigned DEF_POOL_PAGES   = 16;
    localparam int unsigned DEF_PAGE_BYTES   = 4096;
    localparam int unsigned DEF_HEADER_BYTES = 24;
    localparam int unsigned DEF_MAX_BLOCK    = 1024;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef struct packed {
        op_t                 operation;
        logic [SIZE_W-1:0]   req_size;
        logic [ADDR_W-1:0]   block_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_addr;
        status_t             status;
        logic [CLASS_W-1:0]  size_class;
    } rsp_t;

endpackage

// ===== design/scba_ram.sv =====
// ----------------------------------------------------------------------------
// scba_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module scba_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/size_class_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit
// Power-of-two size-class allocator: per-class freed stacks linked through a
// link RAM, per-class carving of fresh pool pages.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req and raise start; the item is taken at a clock
//   edge where start is high and busy is low. busy stays high for the one
//   cycle in which the item is worked on.
//   Response channel: done pulses for exactly one cycle with rsp holding the
//   result item; the receiver takes it at the edge that ends that cycle and
//   cannot stall it.
//   Result: the link RAM read is issued at the accepting edge; state is
//   updated, the result registered and done raised at the next edge.
//   Flow: no item is accepted while busy is high; the next item may be
//   accepted at the same edge that delivers the previous result. The pace is
//   set by the read-modify-write of the link RAM and the per-class stack heads.
//   Reset: rst_n clears every stack head, carving counter, page tag and the
//   page counter at once; no clearing pass is needed. The link RAM is not
//   cleared: only links written by an earlier free are ever read back.
// ----------------------------------------------------------------------------
module size_class_block_allocator_unit
    import scba_pkg::*;
#(
    parameter int unsigned POOL_PAGES   = DEF_POOL_PAGES,
    parameter int unsigned PAGE_BYTES   = DEF_PAGE_BYTES,
    parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES,
    parameter int unsigned MAX_BLOCK    = DEF_MAX_BLOCK
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    // Derived geometry
    localparam int unsigned FIT_PAGES = ADDR_SPACE / PAGE_BYTES;
    localparam int unsigned USABLE    = (POOL_PAGES < FIT_PAGES) ? POOL_PAGES : FIT_PAGES;
    localparam int unsigned PG_CNT_W  = $clog2(USABLE + 1);
    localparam int unsigned PG_W      = (USABLE > 1) ? $clog2(USABLE) : 1;
    localparam int unsigned SPAN      = PAGE_BYTES - HEADER_BYTES;
    localparam int unsigned LEFT_W    = $clog2(SPAN / CLASS_MIN_BYTES + 1);
    localparam int unsigned WIDE_W    = ADDR_W + 1;

    typedef enum logic {
        S_IDLE,
        S_WORK
    } state_t;

    // Control and per-class state
    state_t                 state_reg, state_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    rsp_t                   rsp_reg, rsp_next;

    op_t                    op_reg, op_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [CLASS_W-1:0]     cls_reg, cls_next;
    logic                   large_reg, large_next;

    logic [ADDR_W-1:0]      freed_head_reg [NUM_CLASSES];
    logic [ADDR_W-1:0]      freed_head_next [NUM_CLASSES];
    logic [ADDR_W-1:0]      carve_next_reg [NUM_CLASSES];
    logic [ADDR_W-1:0]      carve_next_next [NUM_CLASSES];
    logic [LEFT_W-1:0]      carve_left_reg [NUM_CLASSES];
    logic [LEFT_W-1:0]      carve_left_next [NUM_CLASSES];
    logic [CLASS_CNT_W-1:0] page_class_reg [USABLE];
    logic [CLASS_CNT_W-1:0] page_class_next [USABLE];
    logic [PG_CNT_W-1:0]    pages_used_reg, pages_used_next;
    logic [ADDR_W-1:0]      page_base_reg, page_base_next;

    // Link RAM ports
    logic                   link_we;
    logic [LINK_IDX_W-1:0]  link_waddr;
    logic [ADDR_W-1:0]      link_wdata;
    logic                   link_re;
    logic [LINK_IDX_W-1:0]  link_raddr;
    logic [ADDR_W-1:0]      link_rdata;

    // Request decode
    logic                   accept;
    logic [SIZE_W-1:0]      size_eff;
    logic [NUM_CLASSES-1:0] below;
    logic [CLASS_CNT_W-1:0] below_cnt;
    logic [CLASS_W-1:0]     cls_in;
    logic                   large_in;

    // Work-cycle helpers
    logic [USABLE-1:0]      page_ge;
    logic [PG_CNT_W-1:0]    page_idx;
    logic                   page_foreign;
    logic [CLASS_CNT_W-1:0] page_tag;
    logic [ADDR_W-1:0]      head;
    logic [ADDR_W-1:0]      blk;
    logic [WIDE_W-1:0]      blocks_wide;
    logic [LEFT_W-1:0]      blocks;
    logic [ADDR_W-1:0]      fresh_addr;

    assign accept = start && !busy_reg;

    // Size to class: count classes too small for the request
    always_comb
    begin
        size_eff = (req.req_size == '0) ? SIZE_W'(1) : req.req_size;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            below[i] = (WIDE_W'(CLASS_MIN_BYTES) << i) < {1'b0, size_eff};
        end
        below_cnt = CLASS_CNT_W'($countones(below));
        cls_in    = below_cnt[CLASS_W-1:0];
        large_in  = ({1'b0, size_eff} > WIDE_W'(MAX_BLOCK)) || below_cnt[CLASS_W];
    end

    // Link read issued at accept, from the head of the requested class
    assign link_re    = accept;
    assign link_raddr = freed_head_reg[cls_in][ADDR_W-1:CLASS_MIN_SHIFT];

    scba_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (LINK_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Page lookup for a free: count page boundaries at or below the address
    always_comb
    begin
        for (int j = 0; j < USABLE; j++)
        begin
            page_ge[j] = {1'b0, addr_reg} >= WIDE_W'((j + 1) * PAGE_BYTES);
        end
        page_idx     = PG_CNT_W'($countones(page_ge));
        page_foreign = (page_idx == PG_CNT_W'(USABLE));
        page_tag     = page_foreign ? '0 : page_class_reg[page_idx[PG_W-1:0]];
    end

    // Class-dependent values for the allocate path
    always_comb
    begin
        head        = freed_head_reg[cls_reg];
        blk         = ADDR_W'(CLASS_MIN_BYTES) << cls_reg;
        blocks_wide = WIDE_W'(SPAN) >> (CLASS_MIN_SHIFT + 32'(cls_reg));
        blocks      = blocks_wide[LEFT_W-1:0];
        fresh_addr  = page_base_reg + ADDR_W'(HEADER_BYTES);
    end

    // Next-state logic
    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        cls_next        = cls_reg;
        large_next      = large_reg;
        freed_head_next = freed_head_reg;
        carve_next_next = carve_next_reg;
        carve_left_next = carve_left_reg;
        page_class_next = page_class_reg;
        pages_used_next = pages_used_reg;
        page_base_next  = page_base_reg;
        link_we         = 1'b0;
        link_waddr      = addr_reg[ADDR_W-1:CLASS_MIN_SHIFT];
        link_wdata      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.operation;
                    addr_next  = req.block_addr;
                    cls_next   = cls_in;
                    large_next = large_in;
                    state_next = S_WORK;
                    busy_next  = 1'b1;
                end
            end
            S_WORK:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
                done_next  = 1'b1;
                if (op_reg == OP_ALLOC)
                begin
                    if (large_reg)
                    begin
                        rsp_next = '{result_addr: '0, status: ST_TOO_LARGE, size_class: '0};
                    end
                    else if (head != '0)
                    begin
                        // pop the freed stack
                        freed_head_next[cls_reg] = link_rdata;
                        rsp_next = '{result_addr: head, status: ST_OK, size_class: cls_reg};
                    end
                    else if (carve_left_reg[cls_reg] != '0)
                    begin
                        // next block of the newest page
                        carve_next_next[cls_reg] = carve_next_reg[cls_reg] + blk;
                        carve_left_next[cls_reg] = carve_left_reg[cls_reg] - LEFT_W'(1);
                        rsp_next = '{result_addr: carve_next_reg[cls_reg], status: ST_OK,
                                     size_class: cls_reg};
                    end
                    else if (pages_used_reg < PG_CNT_W'(USABLE))
                    begin
                        // carve a fresh page
                        page_class_next[pages_used_reg[PG_W-1:0]] =
                            CLASS_CNT_W'(cls_reg) + CLASS_CNT_W'(1);
                        pages_used_next          = pages_used_reg + PG_CNT_W'(1);
                        page_base_next           = page_base_reg + ADDR_W'(PAGE_BYTES);
                        carve_next_next[cls_reg] = fresh_addr + blk;
                        carve_left_next[cls_reg] = (blocks != '0) ? blocks - LEFT_W'(1) : '0;
                        rsp_next = '{result_addr: fresh_addr, status: ST_OK,
                                     size_class: cls_reg};
                    end
                    else
                    begin
                        rsp_next = '{result_addr: '0, status: ST_EXHAUSTED,
                                     size_class: cls_reg};
                    end
                end
                else
                begin
                    if (addr_reg == '0 || page_foreign || page_tag == '0)
                    begin
                        rsp_next = '{result_addr: '0, status: ST_IGNORED, size_class: '0};
                    end
                    else
                    begin
                        // push onto the page's class stack
                        link_we    = 1'b1;
                        link_wdata = freed_head_reg[page_tag[CLASS_W-1:0] - CLASS_W'(1)];
                        freed_head_next[page_tag[CLASS_W-1:0] - CLASS_W'(1)] = addr_reg;
                        rsp_next = '{result_addr: '0, status: ST_OK,
                                     size_class: page_tag[CLASS_W-1:0] - CLASS_W'(1)};
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // State, registered outputs and per-class state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            rsp_reg        <= '0;
            op_reg         <= OP_ALLOC;
            addr_reg       <= '0;
            cls_reg        <= '0;
            large_reg      <= 1'b0;
            pages_used_reg <= '0;
            page_base_reg  <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                freed_head_reg[i] <= '0;
                carve_next_reg[i] <= '0;
                carve_left_reg[i] <= '0;
            end
            for (int p = 0; p < USABLE; p++)
            begin
                page_class_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            rsp_reg        <= rsp_next;
            op_reg         <= op_next;
            addr_reg       <= addr_next;
            cls_reg        <= cls_next;
            large_reg      <= large_next;
            pages_used_reg <= pages_used_next;
            page_base_reg  <= page_base_next;
            freed_head_reg <= freed_head_next;
            carve_next_reg <= carve_next_next;
            carve_left_reg <= carve_left_next;
            page_class_reg <= page_class_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
